>>> design/hrfs_pkg.sv
`default_nettype none

package hrfs_pkg;

    // Report buffer geometry.
    localparam int REPORT_BUFFER_DEPTH = 21;
    localparam int ADDR_W = $clog2(REPORT_BUFFER_DEPTH);
    localparam int LEN_W = 5;
    localparam int REM_W = 6;

    // Frame header.
    localparam logic [7:0] MAGIC_BYTE = 8'h57;
    localparam logic [7:0] GROUP_A = 8'h39;
    localparam logic [7:0] GROUP_B = 8'h4A;
    localparam logic [7:0] GROUP_C = 8'h5B;
    localparam logic [7:0] GROUP_D = 8'h6C;

    // Sub-packet lengths.
    localparam logic [REM_W-1:0] KBD_LEN = 6'd9;
    localparam logic [REM_W-1:0] CONS_LEN = 6'd5;
    localparam logic [REM_W-1:0] MOUSE_LEN = 6'd8;
    localparam logic [REM_W-1:0] TOUCH_LEN = 6'd21;
    localparam logic [REM_W-1:0] VSHORT_LEN = 6'd16;
    localparam logic [REM_W-1:0] VLONG_LEN = 6'd32;

    // Configuration register indexes.
    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] CFG_KBD = 3'd0;
    localparam logic [CFG_W-1:0] CFG_CONS = 3'd1;
    localparam logic [CFG_W-1:0] CFG_MOUSE = 3'd2;
    localparam logic [CFG_W-1:0] CFG_TOUCH = 3'd3;
    localparam logic [CFG_W-1:0] CFG_VSHORT = 3'd4;
    localparam logic [CFG_W-1:0] CFG_VLONG = 3'd5;
    localparam logic [CFG_W-1:0] CFG_REST_A = 3'd6;
    localparam logic [CFG_W-1:0] CFG_REST_B = 3'd7;

    // Request from the parser to read out a completed report.
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } emit_req_t;

endpackage

`default_nettype wire

>>> design/hid_report_frame_splitter_unit.sv
// Splits frames of raw bytes into complete HID reports.
// Input: one frame byte per request on s_tdata, with s_tlast on the final byte
// of the frame. Frames with a bad header are dropped; sub-packets after the
// header are classified by their type byte against the eight type registers.
// Output: one report byte per request on m_tdata, report id first, with m_tlast
// on the final byte of the report. Vendor packets are skipped, and a report cut
// short by the end of its frame is never emitted.
// Bytes are taken one per cycle while s_tready is high. Report bytes go into a
// 21-entry report buffer RAM; the byte that completes a report starts a readout
// of that RAM, one address per cycle while the receiver does not stall, and
// s_tready stays low while the RAM read port is busy with the report (5 to 21
// bytes). Report bytes pass through the RAM output register, then the output
// register, and follow one per cycle while m_tready is high. When the receiver
// stalls, the readout pauses with at most two bytes held, one in each register,
// and input stays blocked until the last address is read. Configuration
// registers are written through cfg_wr_en, cfg_addr and cfg_wr_data; the user
// must do so only while the block is idle, which the block does not enforce.
// Reset (aresetn low, synchronous) restores the default type codes, clears
// frame state and drops any report in flight; buffer contents are not cleared.
`default_nettype none

module hid_report_frame_splitter_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [hrfs_pkg::CFG_W-1:0] cfg_addr,
    input  wire logic [7:0]                 cfg_wr_data,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] data_byte
    input  wire logic                       s_tlast,   // frame_end
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [7:0]                 m_tdata,   // [7:0] report_byte
    output logic                            m_tlast    // report_last
);

    hrfs_pkg::emit_req_t         emit_req;
    logic                        busy;
    logic                        in_accept;
    logic                        wr_en;
    logic [hrfs_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                  wr_data;
    logic                        rd_en;
    logic [hrfs_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  rd_data;

    assign s_tready  = !busy;
    assign in_accept = s_tvalid && s_tready;

    hrfs_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .data_byte   (s_tdata),
        .frame_end   (s_tlast),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .emit_req    (emit_req)
    );

    hrfs_ram #(
        .WIDTH (8),
        .DEPTH (hrfs_pkg::REPORT_BUFFER_DEPTH)
    ) u_report_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hrfs_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit_req (emit_req),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> design/hrfs_ram.sv
`default_nettype none

module hrfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 21
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/hrfs_parser.sv
`default_nettype none

module hrfs_parser (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [hrfs_pkg::CFG_W-1:0]   cfg_addr,
    input  wire logic [7:0]                   cfg_wr_data,
    input  wire logic                         in_accept,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         frame_end,
    output logic                              wr_en,
    output logic      [hrfs_pkg::ADDR_W-1:0]  wr_addr,
    output logic      [7:0]                   wr_data,
    output hrfs_pkg::emit_req_t               emit_req
);

    logic [7:0] cfg_reg [8];

    logic [1:0]                 hdr_pos_reg, hdr_pos_next;
    logic                       halted_reg, halted_next;
    logic [hrfs_pkg::REM_W-1:0] remaining_reg, remaining_next;
    logic                       skipping_reg, skipping_next;
    logic [hrfs_pkg::LEN_W-1:0] rlen_reg, rlen_next;

    logic                       group_ok;
    logic [hrfs_pkg::REM_W-1:0] type_len;
    logic                       type_skip;
    logic [hrfs_pkg::REM_W-1:0] body_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[hrfs_pkg::CFG_KBD]    <= 8'd1;
            cfg_reg[hrfs_pkg::CFG_CONS]   <= 8'd2;
            cfg_reg[hrfs_pkg::CFG_MOUSE]  <= 8'd3;
            cfg_reg[hrfs_pkg::CFG_TOUCH]  <= 8'd4;
            cfg_reg[hrfs_pkg::CFG_VSHORT] <= 8'd5;
            cfg_reg[hrfs_pkg::CFG_VLONG]  <= 8'd6;
            cfg_reg[hrfs_pkg::CFG_REST_A] <= 8'd7;
            cfg_reg[hrfs_pkg::CFG_REST_B] <= 8'd8;
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_addr] <= cfg_wr_data;
        end
    end

    always_comb begin
        group_ok = (data_byte == hrfs_pkg::GROUP_A) || (data_byte == hrfs_pkg::GROUP_B) ||
                   (data_byte == hrfs_pkg::GROUP_C) || (data_byte == hrfs_pkg::GROUP_D);

        // The first matching register wins. Rest-of-frame codes and unknown
        // codes both leave the length at zero, which halts the frame.
        type_len  = '0;
        type_skip = 1'b0;
        if (data_byte == cfg_reg[hrfs_pkg::CFG_KBD]) begin
            type_len = hrfs_pkg::KBD_LEN;
        end else if (data_byte == cfg_reg[hrfs_pkg::CFG_CONS]) begin
            type_len = hrfs_pkg::CONS_LEN;
        end else if (data_byte == cfg_reg[hrfs_pkg::CFG_MOUSE]) begin
            type_len = hrfs_pkg::MOUSE_LEN;
        end else if (data_byte == cfg_reg[hrfs_pkg::CFG_TOUCH]) begin
            type_len = hrfs_pkg::TOUCH_LEN;
        end else if (data_byte == cfg_reg[hrfs_pkg::CFG_VSHORT]) begin
            type_len  = hrfs_pkg::VSHORT_LEN;
            type_skip = 1'b1;
        end else if (data_byte == cfg_reg[hrfs_pkg::CFG_VLONG]) begin
            type_len  = hrfs_pkg::VLONG_LEN;
            type_skip = 1'b1;
        end else if (data_byte == cfg_reg[hrfs_pkg::CFG_REST_A] ||
                     data_byte == cfg_reg[hrfs_pkg::CFG_REST_B]) begin
            type_len = '0;
        end

        body_idx = {1'b0, rlen_reg} - remaining_reg;

        hdr_pos_next   = hdr_pos_reg;
        halted_next    = halted_reg;
        remaining_next = remaining_reg;
        skipping_next  = skipping_reg;
        rlen_next      = rlen_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = data_byte;
        emit_req.start = 1'b0;
        emit_req.len   = rlen_reg;

        if (in_accept) begin
            if (halted_reg) begin
                halted_next = 1'b1;
            end else if (hdr_pos_reg != 2'd3) begin
                if (hdr_pos_reg == 2'd0 && data_byte != hrfs_pkg::MAGIC_BYTE) begin
                    halted_next = 1'b1;
                end else if (hdr_pos_reg == 2'd2 && !group_ok) begin
                    halted_next = 1'b1;
                end
                hdr_pos_next = hdr_pos_reg + 2'd1;
            end else if (remaining_reg == '0) begin
                if (type_len == '0) begin
                    halted_next = 1'b1;
                end else begin
                    skipping_next  = type_skip;
                    remaining_next = type_len - 6'd1;
                    if (!type_skip) begin
                        rlen_next = type_len[hrfs_pkg::LEN_W-1:0];
                        wr_en     = 1'b1;
                    end
                end
            end else if (skipping_reg) begin
                remaining_next = remaining_reg - 6'd1;
                if (remaining_reg == 6'd1) begin
                    skipping_next = 1'b0;
                end
            end else begin
                wr_en          = 1'b1;
                wr_addr        = body_idx[hrfs_pkg::ADDR_W-1:0];
                remaining_next = remaining_reg - 6'd1;
                emit_req.start = (remaining_reg == 6'd1);
            end

            if (frame_end) begin
                hdr_pos_next   = 2'd0;
                halted_next    = 1'b0;
                remaining_next = '0;
                skipping_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos_reg   <= 2'd0;
            halted_reg    <= 1'b0;
            remaining_reg <= '0;
            skipping_reg  <= 1'b0;
            rlen_reg      <= '0;
        end else begin
            hdr_pos_reg   <= hdr_pos_next;
            halted_reg    <= halted_next;
            remaining_reg <= remaining_next;
            skipping_reg  <= skipping_next;
            rlen_reg      <= rlen_next;
        end
    end

endmodule

`default_nettype wire

>>> design/hrfs_emitter.sv
`default_nettype none

module hrfs_emitter (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire hrfs_pkg::emit_req_t         emit_req,
    output logic                             busy,
    output logic                             rd_en,
    output logic     [hrfs_pkg::ADDR_W-1:0]  rd_addr,
    input  wire logic [7:0]                  rd_data,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic     [7:0]                   m_tdata,
    output logic                             m_tlast
);

    logic                        reading_reg, reading_next;
    logic [hrfs_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [hrfs_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                        ram_valid_reg, ram_valid_next;
    logic                        pend_last_reg, pend_last_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;

    logic                        out_free;
    logic                        at_last;

    always_comb begin
        out_free = !out_valid_reg || m_tready;
        at_last  = (addr_reg == len_reg - 5'd1);

        // A new read may overwrite the RAM output register only when its
        // current byte is absent or moves into the output register now.
        rd_en   = reading_reg && (!ram_valid_reg || out_free);
        rd_addr = addr_reg;

        reading_next   = reading_reg;
        addr_next      = addr_reg;
        len_next       = len_reg;
        pend_last_next = pend_last_reg;
        ram_valid_next = rd_en || (ram_valid_reg && !out_free);
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (emit_req.start) begin
            reading_next = 1'b1;
            addr_next    = '0;
            len_next     = emit_req.len;
        end else if (rd_en) begin
            addr_next      = addr_reg + hrfs_pkg::ADDR_W'(1);
            pend_last_next = at_last;
            if (at_last) begin
                reading_next = 1'b0;
            end
        end

        if (ram_valid_reg && out_free) begin
            out_valid_next = 1'b1;
            out_data_next  = rd_data;
            out_last_next  = pend_last_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reading_reg   <= 1'b0;
            ram_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            reading_reg   <= reading_next;
            ram_valid_reg <= ram_valid_next;
            out_valid_reg <= out_valid_next;
        end
        addr_reg      <= addr_next;
        len_reg       <= len_next;
        pend_last_reg <= pend_last_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign busy     = reading_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
